// ===== hdl/json_string_unescaper_core_assert.svh =====
// ----------------------------------------------------------------------------
// json_string_unescaper_core_assert.svh
// Assertion macros shared by the unescaper modules. Clock clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPER_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPER_CORE_ASSERT_SVH

// expression holds at every edge out of reset
`define JSUC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define JSUC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JSUC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and codes shared by the JSON string unescaper front end, request
// queue and output serialiser.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADSTR  = 2'd1;
  localparam logic [1:0] ST_BADUTF8 = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX1,
    MODE_PAIR_BS,
    MODE_PAIR_U,
    MODE_HEX2,
    MODE_SEQ
  } mode_t;

  // one request: up to four data bytes then an optional status item
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      n_data;
    logic            has_st;
    logic [1:0]      st;
  } cmd_t;

endpackage

// ===== hdl/json_string_unescaper_core.sv =====
// ----------------------------------------------------------------------------
// json_string_unescaper_core
// JSON string body unescaper with UTF-8 encoding of \u escapes and checking
// of raw multibyte UTF-8.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the request queue has room. The
// output side gives one result per cycle while out_stall is low, so a byte
// that yields up to one result keeps the full byte-per-cycle rate, while a
// \u escape or completed raw sequence yielding n bytes (plus a status item
// on the last byte) holds the output until all of them are taken. A queue
// of QDEPTH requests between the scanner and the output serialiser absorbs
// these bursts; the input stalls only while that queue is full.
module json_string_unescaper_core #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic [1:0] out_status,
  output logic       out_run_last
);

  logic          accept;
  logic          req_push;
  jsu_pkg::cmd_t req;
  logic          q_full, q_empty, q_pop;
  jsu_pkg::cmd_t q_head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .req_push (req_push),
    .req      (req)
  );

  jsu_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req_push),
    .push_data (req),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  jsu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (q_empty),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_run_last (out_run_last)
  );

endmodule

// ===== hdl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Scanner: takes one byte per cycle while accept is high, tracks escape and
// UTF-8 state and pushes a serialiser request per byte that yields a result.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           req_push,
  output jsu_pkg::cmd_t  req
);

  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_U     = 8'h75;

  jsu_pkg::mode_t mode_r, mode_nxt, mode_step;
  logic [1:0]     hex_cnt_r, hex_cnt_nxt;
  logic [15:0]    hex_val_r, hex_val_nxt;
  logic           bad_hex_r, bad_hex_nxt;
  logic [9:0]     high_r, high_nxt;
  logic [1:0]     need_r, need_nxt;
  logic [1:0]     have_r, have_nxt;
  logic [20:0]    seqv_r, seqv_nxt;
  logic [1:0]     err_r, err_nxt, err_step;
  logic [7:0]     seq_b_r [3];
  logic           seqb_we;
  logic [1:0]     seqb_idx;

  logic [7:0]     c;
  logic           is_hex;
  logic [3:0]     dig;
  logic [15:0]    hex_new;
  logic           bad_new, hex_done, in_high, in_low;
  logic [20:0]    cp2;
  logic           cont, seq_more, seq_bad;
  logic [1:0]     have_inc;
  logic [20:0]    seq_new;
  logic [8:0]     esc;
  logic [1:0]     st_end;

  function automatic logic [8:0] esc_map(input logic [7:0] ch);
    logic [8:0] r;
    r = 9'd0;
    unique case (ch)
      CH_QUOTE, CH_BSL, CH_SLASH: r = {1'b1, ch};
      8'h62:               r = {1'b1, 8'h08};
      8'h66:               r = {1'b1, 8'h0C};
      8'h6E:               r = {1'b1, 8'h0A};
      8'h72:               r = {1'b1, 8'h0D};
      8'h74:               r = {1'b1, 8'h09};
      default:             r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic jsu_pkg::cmd_t encode(input logic [20:0] cp);
    jsu_pkg::cmd_t r;
    r = '0;
    if (cp <= 21'h7F) begin
      r.data[0] = cp[7:0];
      r.n_data  = 3'd1;
    end else if (cp <= 21'h7FF) begin
      r.data[0] = {3'b110, cp[10:6]};
      r.data[1] = {2'b10, cp[5:0]};
      r.n_data  = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      r.data[0] = {4'b1110, cp[15:12]};
      r.data[1] = {2'b10, cp[11:6]};
      r.data[2] = {2'b10, cp[5:0]};
      r.n_data  = 3'd3;
    end else begin
      r.data[0] = {5'b11110, cp[20:18]};
      r.data[1] = {2'b10, cp[17:12]};
      r.data[2] = {2'b10, cp[11:6]};
      r.data[3] = {2'b10, cp[5:0]};
      r.n_data  = 3'd4;
    end
    return r;
  endfunction

  assign c = in_byte;

  always_comb begin
    is_hex = 1'b1;
    dig    = 4'd0;
    priority if (c >= 8'h30 && c <= 8'h39) dig = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66)     dig = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46)     dig = 4'(c - 8'h37);
    else                                   is_hex = 1'b0;
  end

  assign hex_new  = {hex_val_r[11:0], dig};
  assign bad_new  = bad_hex_r | ~is_hex;
  assign hex_done = (hex_cnt_r == 2'd3);
  assign in_high  = (hex_new >= 16'hD800) && (hex_new <= 16'hDBFF);
  assign in_low   = (hex_new >= 16'hDC00) && (hex_new <= 16'hDFFF);
  assign cp2      = 21'h10000 + {1'b0, high_r, hex_new[9:0]};

  assign cont     = (c[7:6] == 2'b10);
  assign seq_new  = {seqv_r[14:0], c[5:0]};
  assign have_inc = have_r + 2'd1;
  assign seq_more = (have_inc < need_r);
  assign seq_bad  = (seq_new >= 21'h0D800 && seq_new <= 21'h0DFFF) ||
                    (need_r == 2'd1 && seq_new < 21'h80) ||
                    (need_r == 2'd2 && seq_new < 21'h800) ||
                    (need_r == 2'd3 && seq_new < 21'h10000) ||
                    (seq_new > 21'h10FFFF);
  assign esc      = esc_map(c);

  // next state
  always_comb begin
    mode_step   = mode_r;
    err_step    = err_r;
    hex_cnt_nxt = hex_cnt_r;
    hex_val_nxt = hex_val_r;
    bad_hex_nxt = bad_hex_r;
    high_nxt    = high_r;
    need_nxt    = need_r;
    have_nxt    = have_r;
    seqv_nxt    = seqv_r;
    seqb_we     = 1'b0;
    seqb_idx    = 2'd0;
    if (err_r == jsu_pkg::ST_OK) begin
      unique case (mode_r)
        jsu_pkg::MODE_NORMAL: begin
          priority if (c == CH_BSL) begin
            mode_step = jsu_pkg::MODE_ESC;
          end else if (c < 8'h20) begin
            err_step = jsu_pkg::ST_BADSTR;
          end else if (c[7]) begin
            priority if (c[7:5] == 3'b110) begin
              need_nxt = 2'd1;
              seqv_nxt = {16'd0, c[4:0]};
            end else if (c[7:4] == 4'b1110) begin
              need_nxt = 2'd2;
              seqv_nxt = {17'd0, c[3:0]};
            end else if (c[7:3] == 5'b11110) begin
              need_nxt = 2'd3;
              seqv_nxt = {18'd0, c[2:0]};
            end else begin
              err_step = jsu_pkg::ST_BADUTF8;
            end
            if (c[7:3] != 5'b11111 && c[7:6] != 2'b10) begin
              seqb_we   = 1'b1;
              have_nxt  = 2'd0;
              mode_step = jsu_pkg::MODE_SEQ;
            end
          end else begin
            mode_step = jsu_pkg::MODE_NORMAL;
          end
        end
        jsu_pkg::MODE_ESC: begin
          mode_step = jsu_pkg::MODE_NORMAL;
          if (c == CH_U) begin
            hex_cnt_nxt = 2'd0;
            hex_val_nxt = 16'd0;
            bad_hex_nxt = 1'b0;
            mode_step   = jsu_pkg::MODE_HEX1;
          end else if (!esc[8]) begin
            err_step = jsu_pkg::ST_BADSTR;
          end
        end
        jsu_pkg::MODE_HEX1: begin
          hex_val_nxt = hex_new;
          bad_hex_nxt = bad_new;
          hex_cnt_nxt = hex_cnt_r + 2'd1;
          if (hex_done) begin
            mode_step = jsu_pkg::MODE_NORMAL;
            priority if (bad_new || in_low) begin
              err_step = jsu_pkg::ST_BADUTF8;
            end else if (in_high) begin
              high_nxt  = hex_new[9:0];
              mode_step = jsu_pkg::MODE_PAIR_BS;
            end else begin
              mode_step = jsu_pkg::MODE_NORMAL;
            end
          end
        end
        jsu_pkg::MODE_PAIR_BS: begin
          if (c == CH_BSL) begin
            mode_step = jsu_pkg::MODE_PAIR_U;
          end else begin
            err_step  = jsu_pkg::ST_BADUTF8;
            mode_step = jsu_pkg::MODE_NORMAL;
          end
        end
        jsu_pkg::MODE_PAIR_U: begin
          if (c == CH_U) begin
            hex_cnt_nxt = 2'd0;
            hex_val_nxt = 16'd0;
            bad_hex_nxt = 1'b0;
            mode_step   = jsu_pkg::MODE_HEX2;
          end else begin
            err_step  = jsu_pkg::ST_BADUTF8;
            mode_step = jsu_pkg::MODE_NORMAL;
          end
        end
        jsu_pkg::MODE_HEX2: begin
          hex_val_nxt = hex_new;
          bad_hex_nxt = bad_new;
          hex_cnt_nxt = hex_cnt_r + 2'd1;
          if (hex_done) begin
            mode_step = jsu_pkg::MODE_NORMAL;
            if (bad_new || !in_low) err_step = jsu_pkg::ST_BADUTF8;
          end
        end
        jsu_pkg::MODE_SEQ: begin
          if (!cont) begin
            err_step  = jsu_pkg::ST_BADUTF8;
            mode_step = jsu_pkg::MODE_NORMAL;
          end else begin
            seqv_nxt = seq_new;
            if (seq_more) begin
              have_nxt = have_inc;
              seqb_we  = 1'b1;
              seqb_idx = have_inc;
            end else begin
              mode_step = jsu_pkg::MODE_NORMAL;
              if (seq_bad) err_step = jsu_pkg::ST_BADUTF8;
            end
          end
        end
        default: mode_step = jsu_pkg::MODE_NORMAL;
      endcase
    end

    mode_nxt = mode_step;
    err_nxt  = err_step;
    if (in_last) begin
      mode_nxt    = jsu_pkg::MODE_NORMAL;
      err_nxt     = jsu_pkg::ST_OK;
      hex_cnt_nxt = 2'd0;
      hex_val_nxt = 16'd0;
      bad_hex_nxt = 1'b0;
      high_nxt    = 10'd0;
      need_nxt    = 2'd0;
      have_nxt    = 2'd0;
      seqv_nxt    = 21'd0;
    end
  end

  always_comb begin
    priority if (err_step != jsu_pkg::ST_OK) begin
      st_end = err_step;
    end else if (mode_step == jsu_pkg::MODE_ESC || mode_step == jsu_pkg::MODE_HEX1) begin
      st_end = jsu_pkg::ST_BADSTR;
    end else if (mode_step != jsu_pkg::MODE_NORMAL) begin
      st_end = jsu_pkg::ST_BADUTF8;
    end else begin
      st_end = jsu_pkg::ST_OK;
    end
  end

  // request for this byte
  always_comb begin
    req = '0;
    if (err_r == jsu_pkg::ST_OK) begin
      unique case (mode_r)
        jsu_pkg::MODE_NORMAL: begin
          if (c >= 8'h20 && !c[7] && c != CH_BSL) begin
            req.data[0] = c;
            req.n_data  = 3'd1;
          end
        end
        jsu_pkg::MODE_ESC: begin
          if (esc[8]) begin
            req.data[0] = esc[7:0];
            req.n_data  = 3'd1;
          end
        end
        jsu_pkg::MODE_HEX1: begin
          if (hex_done && !bad_new && !in_high && !in_low) req = encode({5'd0, hex_new});
        end
        jsu_pkg::MODE_HEX2: begin
          if (hex_done && !bad_new && in_low) req = encode(cp2);
        end
        jsu_pkg::MODE_SEQ: begin
          if (cont && !seq_more && !seq_bad) begin
            req.data[0] = seq_b_r[0];
            req.data[1] = (need_r == 2'd1) ? c : seq_b_r[1];
            req.data[2] = (need_r == 2'd2) ? c : seq_b_r[2];
            req.data[3] = c;
            req.n_data  = {1'b0, need_r} + 3'd1;
          end
        end
        default: req = '0;
      endcase
    end
    if (in_last) begin
      req.has_st = 1'b1;
      req.st     = st_end;
    end
  end

  assign req_push = accept && (req.n_data != 3'd0 || req.has_st);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= jsu_pkg::MODE_NORMAL;
      err_r     <= jsu_pkg::ST_OK;
      hex_cnt_r <= 2'd0;
      hex_val_r <= 16'd0;
      bad_hex_r <= 1'b0;
      high_r    <= 10'd0;
      need_r    <= 2'd0;
      have_r    <= 2'd0;
      seqv_r    <= 21'd0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      err_r     <= err_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      hex_val_r <= hex_val_nxt;
      bad_hex_r <= bad_hex_nxt;
      high_r    <= high_nxt;
      need_r    <= need_nxt;
      have_r    <= have_nxt;
      seqv_r    <= seqv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && seqb_we) seq_b_r[seqb_idx] <= c;
  end

endmodule

// ===== hdl/jsu_fifo.sv =====
// ----------------------------------------------------------------------------
// jsu_fifo
// Short request queue between the scanner and the output serialiser.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_core_assert.svh"

module jsu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output jsu_pkg::cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t  mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop)  rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  `JSUC_ASSERT(a_no_overflow, !(push && full), "request pushed into full queue")
  `JSUC_ASSERT(a_no_underflow, !(pop && empty), "request popped from empty queue")
  `JSUC_ASSERT(a_cnt_range, cnt_r <= CW'(DEPTH), "queue count out of range")

endmodule

// ===== hdl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Output serialiser: walks the head request one result per cycle while
// out_stall is low, data bytes first, then the status item.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_core_assert.svh"

module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  jsu_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_kind,
  output logic [7:0]    out_byte,
  output logic [1:0]    out_status,
  output logic          out_run_last
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       is_data;
  logic       acc;

  assign total        = head.n_data + {2'd0, head.has_st};
  assign is_data      = (idx_r < head.n_data);
  assign out_valid    = !empty;
  assign out_kind     = is_data ? jsu_pkg::KIND_DATA : jsu_pkg::KIND_STATUS;
  assign out_byte     = is_data ? head.data[idx_r[1:0]] : 8'd0;
  assign out_status   = is_data ? jsu_pkg::ST_OK : head.st;
  assign out_run_last = (idx_r == total - 3'd1);

  assign acc = out_valid && !out_stall;
  assign pop = acc && out_run_last;

  always_comb begin
    idx_nxt = idx_r;
    if (acc) idx_nxt = out_run_last ? 3'd0 : idx_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  `JSUC_ASSERT_IMPL(a_head_nonempty, !empty, total != 3'd0, "empty request in queue")
  `JSUC_ASSERT_IMPL(a_idx_range, !empty, idx_r < total, "result index past request")
  `JSUC_ASSERT_NEXT(a_idx_wrap, pop, idx_r == 3'd0, "result index not cleared on pop")

endmodule

// ===== tb/tb_json_string_unescaper_core.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_unescaper_core
// Self-checking bench for the JSON string unescaper. Strings are sent a byte
// per request with random gaps. Each accepted byte runs through a local
// decoder that queues the data bytes and status items it should yield, and
// every result taken from the block is compared field by field with the
// oldest of them. The output side stalls at random, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_json_string_unescaper_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octet_t;
  typedef octet_t octet_q_t[$];

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       run_last;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic       out_run_last;

  result_t  pending_results[$];
  octet_q_t str_bytes;
  int       err_count = 0;
  bit       steady = 1'b0;
  bit       hold_out = 1'b0;

  // decoder state
  jsu_pkg::mode_t scan_st;
  logic [2:0]  digit_cnt;
  logic [15:0] code_acc;
  logic        bad_digit;
  logic [9:0]  high_bits;
  logic [7:0]  held[3];
  logic [1:0]  need_cnt;
  logic [1:0]  have_cnt;
  logic [20:0] raw_cp;
  logic [1:0]  str_status;

  json_string_unescaper_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_status   (out_status),
    .out_run_last (out_run_last)
  );

  always #5ns clk = ~clk;

  function automatic octet_q_t utf8_bytes(input logic [20:0] cp);
    octet_q_t q;
    if (cp < 21'h80) begin
      q.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      q = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
    end else if (cp < 21'h10000) begin
      q = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
    end else begin
      q = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
            {2'b10, cp[5:0]}};
    end
    return q;
  endfunction

  function automatic void clear_decoder();
    scan_st    = jsu_pkg::MODE_NORMAL;
    digit_cnt  = '0;
    code_acc   = '0;
    bad_digit  = 1'b0;
    high_bits  = '0;
    held       = '{default: '0};
    need_cnt   = '0;
    have_cnt   = '0;
    raw_cp     = '0;
    str_status = jsu_pkg::ST_OK;
  endfunction

  function automatic void put_data(input logic [7:0] b);
    pending_results.push_back('{jsu_pkg::KIND_DATA, b, jsu_pkg::ST_OK, 1'b0});
  endfunction

  function automatic void put_code_point(input logic [20:0] cp);
    octet_q_t enc;
    enc = utf8_bytes(cp);
    foreach (enc[i]) put_data(enc[i]);
  endfunction

  function automatic void abort_string(input logic [1:0] st);
    str_status = st;
    scan_st    = jsu_pkg::MODE_NORMAL;
  endfunction

  function automatic void start_digits(input jsu_pkg::mode_t nxt);
    digit_cnt = '0;
    code_acc  = '0;
    bad_digit = 1'b0;
    scan_st   = nxt;
  endfunction

  function automatic void shift_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= "0" && c <= "9") d = 4'(c - 8'h30);
    else if (c >= "a" && c <= "f") d = 4'(c - 8'h61 + 8'd10);
    else if (c >= "A" && c <= "F") d = 4'(c - 8'h41 + 8'd10);
    else bad_digit = 1'b1;
    code_acc  = {code_acc[11:0], d};
    digit_cnt = digit_cnt + 3'd1;
  endfunction

  // expected results for one accepted byte
  function automatic void unescape_byte(input logic [7:0] c, input logic last);
    int          first;
    logic [20:0] v;
    first = pending_results.size();
    if (str_status == jsu_pkg::ST_OK) begin
      case (scan_st)
        jsu_pkg::MODE_NORMAL: begin
          if (c == "\\") begin
            scan_st = jsu_pkg::MODE_ESC;
          end else if (c < 8'h20) begin
            abort_string(jsu_pkg::ST_BADSTR);
          end else if (c < 8'h80) begin
            put_data(c);
          end else begin
            if (c[7:5] == 3'b110) begin
              need_cnt = 2'd1;
              raw_cp   = {16'd0, c[4:0]};
            end else if (c[7:4] == 4'b1110) begin
              need_cnt = 2'd2;
              raw_cp   = {17'd0, c[3:0]};
            end else if (c[7:3] == 5'b11110) begin
              need_cnt = 2'd3;
              raw_cp   = {18'd0, c[2:0]};
            end else begin
              need_cnt = 2'd0;
            end
            if (need_cnt == 2'd0) begin
              abort_string(jsu_pkg::ST_BADUTF8);
            end else begin
              held[0]  = c;
              have_cnt = 2'd0;
              scan_st  = jsu_pkg::MODE_SEQ;
            end
          end
        end
        jsu_pkg::MODE_ESC: begin
          scan_st = jsu_pkg::MODE_NORMAL;
          case (c)
            "\"", "\\", "/": put_data(c);
            "b": put_data(8'h08);
            "f": put_data(8'h0C);
            "n": put_data(8'h0A);
            "r": put_data(8'h0D);
            "t": put_data(8'h09);
            "u": start_digits(jsu_pkg::MODE_HEX1);
            default: abort_string(jsu_pkg::ST_BADSTR);
          endcase
        end
        jsu_pkg::MODE_HEX1: begin
          shift_digit(c);
          if (digit_cnt == 3'd4) begin
            if (bad_digit) begin
              abort_string(jsu_pkg::ST_BADUTF8);
            end else if (code_acc >= 16'hD800 && code_acc <= 16'hDBFF) begin
              high_bits = code_acc[9:0];
              scan_st   = jsu_pkg::MODE_PAIR_BS;
            end else if (code_acc >= 16'hDC00 && code_acc <= 16'hDFFF) begin
              abort_string(jsu_pkg::ST_BADUTF8);
            end else begin
              put_code_point({5'd0, code_acc});
              scan_st = jsu_pkg::MODE_NORMAL;
            end
          end
        end
        jsu_pkg::MODE_PAIR_BS: begin
          if (c == "\\") scan_st = jsu_pkg::MODE_PAIR_U;
          else abort_string(jsu_pkg::ST_BADUTF8);
        end
        jsu_pkg::MODE_PAIR_U: begin
          if (c == "u") start_digits(jsu_pkg::MODE_HEX2);
          else abort_string(jsu_pkg::ST_BADUTF8);
        end
        jsu_pkg::MODE_HEX2: begin
          shift_digit(c);
          if (digit_cnt == 3'd4) begin
            if (bad_digit || code_acc < 16'hDC00 || code_acc > 16'hDFFF) begin
              abort_string(jsu_pkg::ST_BADUTF8);
            end else begin
              put_code_point(21'h10000 + {1'b0, high_bits, code_acc[9:0]});
              scan_st = jsu_pkg::MODE_NORMAL;
            end
          end
        end
        jsu_pkg::MODE_SEQ: begin
          if (c[7:6] != 2'b10) begin
            abort_string(jsu_pkg::ST_BADUTF8);
          end else begin
            raw_cp = {raw_cp[14:0], c[5:0]};
            if (int'(have_cnt) + 1 < int'(need_cnt)) begin
              have_cnt       = have_cnt + 2'd1;
              held[have_cnt] = c;
            end else begin
              v = raw_cp;
              if ((v >= 21'hD800 && v <= 21'hDFFF) ||
                  (need_cnt == 2'd1 && v < 21'h80) ||
                  (need_cnt == 2'd2 && v < 21'h800) ||
                  (need_cnt == 2'd3 && v < 21'h10000) ||
                  v > 21'h10FFFF) begin
                abort_string(jsu_pkg::ST_BADUTF8);
              end else begin
                for (int i = 0; i < int'(need_cnt); i++) put_data(held[i]);
                put_data(c);
                scan_st = jsu_pkg::MODE_NORMAL;
              end
            end
          end
        end
        default: scan_st = jsu_pkg::MODE_NORMAL;
      endcase
    end
    if (last) begin
      if (str_status == jsu_pkg::ST_OK) begin
        if (scan_st == jsu_pkg::MODE_ESC || scan_st == jsu_pkg::MODE_HEX1)
          str_status = jsu_pkg::ST_BADSTR;
        else if (scan_st != jsu_pkg::MODE_NORMAL)
          str_status = jsu_pkg::ST_BADUTF8;
      end
      pending_results.push_back('{jsu_pkg::KIND_STATUS, 8'h00, str_status, 1'b0});
      clear_decoder();
    end
    if (pending_results.size() > first)
      pending_results[pending_results.size() - 1].run_last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
    err_count++;
    if (err_count <= 30)
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got_v, want_v);
  endtask

  always @(posedge clk) begin : result_mon
    result_t got;
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) unescape_byte(in_byte, in_last);
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_byte, out_status, out_run_last};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", {7'd0, got.kind}, 8'h00);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch("kind", 8'(got.kind), 8'(want.kind));
          if (got.data !== want.data) report_mismatch("byte", got.data, want.data);
          if (got.status !== want.status)
            report_mismatch("status", 8'(got.status), 8'(want.status));
          if (got.run_last !== want.run_last)
            report_mismatch("run_last", 8'(got.run_last), 8'(want.run_last));
        end
      end
    end
  end

  function automatic int pause_len();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output backpressure
  int  stall_run = 0;
  bit  stall_on = 1'b0;
  always @(negedge clk) begin
    if (hold_out) begin
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_on  = ($urandom_range(0, 2) == 0);
        stall_run = stall_on ? pause_len() : $urandom_range(1, 10);
      end
      stall_run--;
      out_stall <= stall_on;
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (!steady && $urandom_range(0, 3) == 0) ? pause_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_string(inout int n_sent);
    foreach (str_bytes[i]) offer_byte(str_bytes[i], i == str_bytes.size() - 1);
    n_sent += str_bytes.size();
    str_bytes.delete();
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
  endfunction

  function automatic octet_t hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
  endfunction

  function automatic void add_uesc(input logic [15:0] v);
    str_bytes.push_back("\\");
    str_bytes.push_back("u");
    for (int i = 3; i >= 0; i--) str_bytes.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void add_token();
    logic [31:0] cpv;
    octet_t      esc_set[8];
    esc_set = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
    case ($urandom_range(0, 6))
      0: begin
        cpv = $urandom_range(32'h20, 32'h7F);
        if (cpv[7:0] == "\\") add_str("\\\\");
        else str_bytes.push_back(cpv[7:0]);
      end
      1: begin
        str_bytes.push_back("\\");
        str_bytes.push_back(esc_set[$urandom_range(0, 7)]);
      end
      2: begin
        cpv = $urandom_range(0, 32'hFFFF);
        if (cpv >= 32'hD800 && cpv <= 32'hDFFF) cpv -= 32'h800;
        add_uesc(cpv[15:0]);
      end
      3: begin
        cpv = $urandom_range(32'h10000, 32'h10FFFF) - 32'h10000;
        add_uesc({6'b110110, cpv[19:10]});
        add_uesc({6'b110111, cpv[9:0]});
      end
      4: str_bytes = {str_bytes, utf8_bytes(21'($urandom_range(32'h80, 32'h7FF)))};
      5: begin
        cpv = $urandom_range(32'h800, 32'hFFFF);
        if (cpv >= 32'hD800 && cpv <= 32'hDFFF) cpv -= 32'h800;
        str_bytes = {str_bytes, utf8_bytes(cpv[20:0])};
      end
      default:
        str_bytes = {str_bytes, utf8_bytes(21'($urandom_range(32'h10000, 32'h10FFFF)))};
    endcase
  endfunction

  task automatic test_valid_text(inout int n_sent);
    add_str("A ~");
    str_bytes.push_back(8'h7F);
    add_str("\\\"\\\\\\/\\b\\f\\n\\r\\t");
    send_string(n_sent);
    add_uesc(16'h0000); add_uesc(16'h007F); add_uesc(16'h0080); add_uesc(16'h07FF);
    add_uesc(16'h0800); add_uesc(16'hFFFF);
    add_uesc(16'hD83D); add_uesc(16'hDE00);
    add_uesc(16'hD800); add_uesc(16'hDC00);
    add_uesc(16'hDBFF); add_uesc(16'hDFFF);
    send_string(n_sent);
    str_bytes = '{8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                  8'hED, 8'h9F, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string(n_sent);
    add_str("Z");
    send_string(n_sent);
    wait_results_done();
  endtask

  task automatic test_error_cases(inout int n_sent);
    // control byte, then bytes that must be ignored
    str_bytes = '{"a", 8'h01, "b", "\\", "n", 8'hC2, 8'h80};
    send_string(n_sent);
    str_bytes = '{8'h00};
    send_string(n_sent);
    add_str("ab"); str_bytes.push_back(8'h1F);
    send_string(n_sent);
    add_str("\\q");   send_string(n_sent);
    add_str("x\\");   send_string(n_sent);
    add_str("\\u12"); send_string(n_sent);
    add_str("\\u1G"); send_string(n_sent);
    add_str("\\u12G4x"); send_string(n_sent);
    add_uesc(16'hDC00); send_string(n_sent);
    add_uesc(16'hDFFF); add_str("y"); send_string(n_sent);
    // broken surrogate pairs
    add_uesc(16'hD800); send_string(n_sent);
    add_uesc(16'hD800); add_str("a"); send_string(n_sent);
    add_uesc(16'hD800); add_str("\\n"); send_string(n_sent);
    add_uesc(16'hD800); add_uesc(16'h0041); send_string(n_sent);
    add_uesc(16'hD800); add_str("\\uDC0"); send_string(n_sent);
    add_uesc(16'hDBFF); add_uesc(16'hE000); send_string(n_sent);
    add_uesc(16'hD800); add_str("\\uDCxG"); send_string(n_sent);
    // raw UTF-8 faults
    str_bytes = '{"x", 8'h80};               send_string(n_sent);
    str_bytes = '{"x", 8'hF8, "y"};          send_string(n_sent);
    str_bytes = '{8'hFF};                    send_string(n_sent);
    str_bytes = '{8'hC2, 8'h41};             send_string(n_sent);
    str_bytes = '{"x", 8'hE0, 8'hA0};        send_string(n_sent);
    str_bytes = '{8'hC0, 8'h80, 8'hC1, 8'hBF}; send_string(n_sent);
    str_bytes = '{8'hE0, 8'h9F, 8'hBF};      send_string(n_sent);
    str_bytes = '{8'hF0, 8'h8F, 8'hBF, 8'hBF}; send_string(n_sent);
    str_bytes = '{8'hED, 8'hA0, 8'h80};      send_string(n_sent);
    str_bytes = '{8'hED, 8'hBF, 8'hBF};      send_string(n_sent);
    str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_string(n_sent);
    str_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF}; send_string(n_sent);
    wait_results_done();
  endtask

  task automatic test_output_hold(inout int n_sent);
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
    join_none
    repeat (4) begin
      repeat (4) add_token();
      send_string(n_sent);
    end
    wait_results_done();
  endtask

  task automatic test_random_strings(input int target);
    int n_sent;
    int pick;
    n_sent = 0;
    while (n_sent < target) begin
      steady = (n_sent < target / 4);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 8)) str_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) add_token();
        if (pick < 18) begin
          str_bytes[$urandom_range(0, str_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick < 25) begin
          str_bytes = str_bytes[0:$urandom_range(0, str_bytes.size() - 1)];
        end
      end
      send_string(n_sent);
      if ($urandom_range(0, 9) == 0) wait_results_done();
    end
    steady = 1'b0;
    wait_results_done();
  endtask

  initial begin
    int n_directed;
    n_directed = 0;
    clear_decoder();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_valid_text(n_directed);
    test_error_cases(n_directed);
    test_output_hold(n_directed);
    test_random_strings(450 - n_directed);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
